// File: rtl/att_pkg.sv
`default_nettype none

package att_pkg;

    localparam int BUCKETS   = 256;
    localparam int WAYS      = 4;
    localparam int ADDR_BITS = 48;

    localparam int ROW_W    = $clog2(BUCKETS);
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOTS    = BUCKETS * WAYS;
    localparam int HASH_W   = 64;
    localparam int SIZE_W   = 32;
    localparam int SEQ_W    = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 11;
    localparam int TOT_W    = 16;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [KIND_W-1:0] ALLOC_MALLOC    = 3'd0;
    localparam logic [KIND_W-1:0] ALLOC_CALLOC    = 3'd1;
    localparam logic [KIND_W-1:0] ALLOC_REALLOC   = 3'd2;
    localparam logic [KIND_W-1:0] ALLOC_NEW       = 3'd3;
    localparam logic [KIND_W-1:0] ALLOC_NEW_ARRAY = 3'd4;

    localparam logic [KIND_W-1:0] REL_FREE         = 3'd0;
    localparam logic [KIND_W-1:0] REL_REALLOC      = 3'd1;
    localparam logic [KIND_W-1:0] REL_DELETE       = 3'd2;
    localparam logic [KIND_W-1:0] REL_DELETE_ARRAY = 3'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNKNOWN   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic                guard_intact;
        logic [KIND_W-1:0]   kind;
        logic [SIZE_W-1:0]   size_bytes;
        logic [ADDR_BITS-1:0] address;
    } in_word_t;

    typedef struct packed {
        logic [TOT_W-1:0]    overflow_total;
        logic [TOT_W-1:0]    mismatch_total;
        logic [TOT_W-1:0]    bad_free_total;
        logic [SIZE_W-1:0]   live_bytes;
        logic [CNT_W-1:0]    live_count;
        logic                overflow_flag;
        logic                mismatch_flag;
        logic [SEQ_W-1:0]    sequence_res;
        logic [SIZE_W-1:0]   freed_size;
        logic [STATUS_W-1:0] status;
    } out_word_t;

    localparam int IN_BITS     = $bits(in_word_t);
    localparam int OUT_BITS    = $bits(out_word_t);
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic                 valid;
        logic [ADDR_BITS-1:0] address;
        logic [SIZE_W-1:0]    size_bytes;
        logic [KIND_W-1:0]    kind;
        logic [SEQ_W-1:0]     seq_num;
    } way_t;

    typedef way_t [WAYS-1:0] row_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH1,
        ST_HASH2,
        ST_HASH3,
        ST_READ,
        ST_EVAL
    } state_t;

endpackage

`default_nettype wire

// File: rtl/allocation_tracking_table.sv
`default_nettype none

// Allocation tracking table. Each input word either records an allocation or releases one,
// and every input word yields exactly one result word carrying the status and the running
// totals. An item is accepted and captured, passes the pipelined address hash, then the
// synchronous read of the bucket row, and is then evaluated: the ways are compared, the row
// is written back and the output register is loaded. Evaluation waits while the output
// register still holds a result that m_axis_tready has not taken. A new word is accepted
// only after the previous one has been evaluated; the output register lets the next word be
// accepted while a result still waits.
// After reset the block sweeps all BUCKETS (256) rows of the bucket memory to clear the valid
// bits and holds s_axis_tready low until the sweep is done.

module allocation_tracking_table
    import att_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // address, size_bytes, kind, guard_intact
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // operation
    input  wire logic [0:0]             s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // status, freed_size, sequence_res, mismatch_flag, overflow_flag, live_count, live_bytes,
    // bad_free_total, mismatch_total, overflow_total
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

    function automatic logic kinds_fit(input logic [KIND_W-1:0] alloc_kind,
                                       input logic [KIND_W-1:0] rel_kind);
        logic fit;
        fit = 1'b0;
        case (rel_kind)
            REL_FREE, REL_REALLOC:
                fit = alloc_kind inside {ALLOC_MALLOC, ALLOC_CALLOC, ALLOC_REALLOC};
            REL_DELETE:
                fit = (alloc_kind == ALLOC_NEW);
            REL_DELETE_ARRAY:
                fit = (alloc_kind == ALLOC_NEW_ARRAY);
            default:
                fit = 1'b0;
        endcase
        return fit;
    endfunction

    function automatic logic [TOT_W-1:0] sat_inc(input logic [TOT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    state_t           state_reg;
    state_t           state_next;
    logic [ROW_W-1:0] clr_idx_reg;
    logic [ROW_W-1:0] clr_idx_next;

    logic             op_reg;
    in_word_t         item_reg;
    logic             accept;

    logic [ROW_W-1:0] row;
    row_t             mem [BUCKETS];
    row_t             rd_row_reg;
    row_t             wr_row;
    logic             mem_we;
    logic [ROW_W-1:0] mem_waddr;
    row_t             mem_wdata;

    logic             ev_go;
    logic             found;
    logic             have_free;
    logic [WAY_W-1:0] hit_idx;
    logic [WAY_W-1:0] free_idx;
    logic             do_store;
    logic             do_remove;
    logic [SIZE_W:0]  bytes_sum;

    logic [SEQ_W-1:0]  next_seq_reg;
    logic [SEQ_W-1:0]  next_seq_next;
    logic [CNT_W-1:0]  count_live_reg;
    logic [CNT_W-1:0]  count_live_next;
    logic [SIZE_W-1:0] bytes_live_reg;
    logic [SIZE_W-1:0] bytes_live_next;
    logic [TOT_W-1:0]  bad_free_reg;
    logic [TOT_W-1:0]  bad_free_next;
    logic [TOT_W-1:0]  mismatch_reg;
    logic [TOT_W-1:0]  mismatch_next;
    logic [TOT_W-1:0]  overflow_reg;
    logic [TOT_W-1:0]  overflow_next;

    out_word_t         result;
    out_word_t         out_word_reg;
    logic              out_valid_reg;
    logic              out_valid_next;

    att_hash u_hash
    (
        .clk     (clk),
        .address (item_reg.address),
        .row     (row)
    );

    assign accept = s_axis_tvalid && s_axis_tready;
    assign ev_go  = (state_reg == ST_EVAL) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == ROW_W'(BUCKETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = ST_HASH1;
                end
            end
            ST_HASH1: state_next = ST_HASH2;
            ST_HASH2: state_next = ST_HASH3;
            ST_HASH3: state_next = ST_READ;
            ST_READ:  state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (ev_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        found     = 1'b0;
        have_free = 1'b0;
        hit_idx   = '0;
        free_idx  = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (rd_row_reg[w].valid)
            begin
                if (!found && rd_row_reg[w].address == item_reg.address)
                begin
                    found   = 1'b1;
                    hit_idx = WAY_W'(w);
                end
            end
            else if (!have_free)
            begin
                have_free = 1'b1;
                free_idx  = WAY_W'(w);
            end
        end

        do_store  = (op_reg == OP_ALLOC) && !found && have_free;
        do_remove = (op_reg == OP_RELEASE) && found;
        bytes_sum = {1'b0, bytes_live_reg} + {1'b0, item_reg.size_bytes};

        wr_row = rd_row_reg;
        if (do_store)
        begin
            wr_row[free_idx].valid      = 1'b1;
            wr_row[free_idx].address    = item_reg.address;
            wr_row[free_idx].size_bytes = item_reg.size_bytes;
            wr_row[free_idx].kind       = item_reg.kind;
            wr_row[free_idx].seq_num    = next_seq_reg;
        end
        if (do_remove)
        begin
            wr_row[hit_idx].valid = 1'b0;
        end

        next_seq_next   = next_seq_reg;
        count_live_next = count_live_reg;
        bytes_live_next = bytes_live_reg;
        bad_free_next   = bad_free_reg;
        mismatch_next   = mismatch_reg;
        overflow_next   = overflow_reg;

        result               = '0;
        result.status        = STATUS_OK;

        if (op_reg == OP_ALLOC)
        begin
            if (found)
            begin
                result.status = STATUS_DUPLICATE;
            end
            else if (!have_free)
            begin
                result.status = STATUS_FULL;
            end
            else
            begin
                result.sequence_res = next_seq_reg;
                next_seq_next       = next_seq_reg + 1'b1;
                count_live_next     = count_live_reg + 1'b1;
                bytes_live_next     = bytes_sum[SIZE_W] ? '1 : bytes_sum[SIZE_W-1:0];
            end
        end
        else
        begin
            if (!found)
            begin
                result.status = STATUS_UNKNOWN;
                bad_free_next = sat_inc(bad_free_reg);
            end
            else
            begin
                result.freed_size   = rd_row_reg[hit_idx].size_bytes;
                result.sequence_res = rd_row_reg[hit_idx].seq_num;
                if (count_live_reg != '0)
                begin
                    count_live_next = count_live_reg - 1'b1;
                end
                bytes_live_next = (bytes_live_reg > rd_row_reg[hit_idx].size_bytes)
                                ? bytes_live_reg - rd_row_reg[hit_idx].size_bytes : '0;
                if (!item_reg.guard_intact)
                begin
                    result.overflow_flag = 1'b1;
                    overflow_next        = sat_inc(overflow_reg);
                end
                if (!kinds_fit(rd_row_reg[hit_idx].kind, item_reg.kind))
                begin
                    result.mismatch_flag = 1'b1;
                    mismatch_next        = sat_inc(mismatch_reg);
                end
            end
        end

        result.live_count     = count_live_next;
        result.live_bytes     = bytes_live_next;
        result.bad_free_total = bad_free_next;
        result.mismatch_total = mismatch_next;
        result.overflow_total = overflow_next;

        if (ev_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = ev_go && (do_store || do_remove);
            mem_waddr = row;
            mem_wdata = wr_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_row_reg <= mem[row];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
            next_seq_reg   <= '0;
            count_live_reg <= '0;
            bytes_live_reg <= '0;
            bad_free_reg   <= '0;
            mismatch_reg   <= '0;
            overflow_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
            if (ev_go)
            begin
                next_seq_reg   <= next_seq_next;
                count_live_reg <= count_live_next;
                bytes_live_reg <= bytes_live_next;
                bad_free_reg   <= bad_free_next;
                mismatch_reg   <= mismatch_next;
                overflow_reg   <= overflow_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= s_axis_tuser[0];
            item_reg <= in_word_t'(s_axis_tdata[IN_BITS-1:0]);
        end
        if (ev_go)
        begin
            out_word_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_word_reg);

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_HASH1))
        else $error("accepted word did not start the hash sequence");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EVAL))
        else $error("result appeared without an evaluation cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_live_reg <= CNT_W'(SLOTS))
        else $error("live count exceeds the table capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_live_reg == $past(count_live_reg))
        || (count_live_reg == $past(count_live_reg) + 1'b1)
        || (count_live_reg == $past(count_live_reg) - 1'b1))
        else $error("live count moved by more than one record");
`endif

endmodule

`default_nettype wire

// File: rtl/att_hash.sv
`default_nettype none

module att_hash
    import att_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic [ADDR_BITS-1:0] address,
    output logic      [ROW_W-1:0]     row
);

    logic [HASH_W-1:0] a0;
    logic [HASH_W-1:0] s1_sum;
    logic [HASH_W-1:0] s1_next;
    logic [HASH_W-1:0] s1_reg;
    logic [HASH_W-1:0] s2_sum;
    logic [HASH_W-1:0] s2_next;
    logic [HASH_W-1:0] s2_reg;
    logic [HASH_W-1:0] s3_sum;
    logic [HASH_W-1:0] s3_next;
    logic [ROW_W-1:0]  row_reg;

    // The final step XORs a copy shifted right by 28; row is taken from its low bits.
    always_comb
    begin
        a0      = HASH_W'(address);
        s1_sum  = (~a0) + (a0 << 21);
        s1_next = s1_sum ^ (s1_sum >> 24);
        s2_sum  = s1_reg + (s1_reg << 3) + (s1_reg << 8);
        s2_next = s2_sum ^ (s2_sum >> 14);
        s3_sum  = s2_reg + (s2_reg << 2) + (s2_reg << 4);
        s3_next = s3_sum ^ (s3_sum >> 28);
    end

    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        s2_reg  <= s2_next;
        row_reg <= s3_next[ROW_W-1:0];
    end

    assign row = row_reg;

endmodule

`default_nettype wire
